FILE: src/lcdseq_pkg.sv
package lcdseq_pkg;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_WRITE   = 2'd1,
        OP_REFRESH = 2'd2,
        OP_REINIT  = 2'd3
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [6:0] index;
        logic [7:0] code;
    } item_t;

    typedef struct packed {
        logic       is_data;
        logic [7:0] bus_byte;
    } result_t;

    // Buffer write request from the sequencer to the character store.
    typedef struct packed {
        logic       en;
        logic [6:0] addr;
        logic [7:0] data;
    } buf_wr_t;

    localparam logic [15:0] STARTUP_WAIT_RESET = 16'd400;
    localparam int          INIT_STEPS         = 7;

    localparam logic [7:0] CMD_LINE0 = 8'h80;
    localparam logic [7:0] CMD_LINE1 = 8'hC0;
    localparam logic [7:0] CMD_LINE2 = 8'h94;
    localparam logic [7:0] CMD_LINE3 = 8'hD4;

    localparam int LINE1_POS = 20;
    localparam int LINE2_POS = 40;
    localparam int LINE3_POS = 60;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] GLYPH_BASE = 8'hC0;

    localparam logic [7:0] GLYPH_MAP [64] = '{
        8'h41, 8'hA0, 8'h42, 8'hA1, 8'hE0, 8'h45, 8'hA3, 8'hA4,
        8'hA5, 8'hA6, 8'h4B, 8'hA7, 8'h4D, 8'h48, 8'h4F, 8'hA8,
        8'h50, 8'h43, 8'h54, 8'hA9, 8'hAA, 8'h58, 8'hE1, 8'hAB,
        8'hAC, 8'hE2, 8'hAD, 8'hAE, 8'h62, 8'hAF, 8'hB0, 8'hB1,
        8'h61, 8'hB2, 8'hB3, 8'hB4, 8'hE3, 8'h65, 8'hB6, 8'hB7,
        8'hB8, 8'hB9, 8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'h6F, 8'hBE,
        8'h70, 8'h63, 8'hBF, 8'h79, 8'hE4, 8'h78, 8'hE5, 8'hC0,
        8'hC1, 8'hE6, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7
    };

    function automatic logic [7:0] init_cmd(input logic [2:0] step);
        logic [7:0] cmd;
        case (step)
            3'd0:    cmd = 8'h38;
            3'd1:    cmd = 8'h38;
            3'd2:    cmd = 8'h38;
            3'd3:    cmd = 8'h14;
            3'd4:    cmd = 8'h06;
            3'd5:    cmd = 8'h02;
            3'd6:    cmd = 8'h0C;
            default: cmd = 8'h0C;
        endcase
        return cmd;
    endfunction

    function automatic logic [15:0] init_wait(input logic [2:0] step);
        logic [15:0] ticks;
        case (step)
            3'd0:    ticks = 16'd50;
            3'd1:    ticks = 16'd10;
            3'd2:    ticks = 16'd2;
            3'd3:    ticks = 16'd2;
            3'd4:    ticks = 16'd2;
            3'd5:    ticks = 16'd40;
            3'd6:    ticks = 16'd2;
            default: ticks = 16'd2;
        endcase
        return ticks;
    endfunction

    function automatic logic [7:0] convert_char(input logic [7:0] code);
        logic [7:0] conv;
        if (code >= GLYPH_BASE) begin
            conv = GLYPH_MAP[code[5:0]];
        end else if (code == 8'h00) begin
            conv = CHAR_SPACE;
        end else begin
            conv = code;
        end
        return conv;
    endfunction

endpackage

FILE: src/lcdseq_item_if.sv
interface lcdseq_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [6:0] buffer_index;
    logic [7:0] char_code;

    modport source (output valid, output operation, output buffer_index, output char_code,
                    input ready);
    modport sink   (input valid, input operation, input buffer_index, input char_code,
                    output ready);
endinterface

FILE: src/lcdseq_bus_if.sv
interface lcdseq_bus_if;
    logic       valid;
    logic       ready;
    logic       is_data;
    logic [7:0] bus_byte;

    modport source (output valid, output is_data, output bus_byte, input ready);
    modport sink   (input valid, input is_data, input bus_byte, output ready);
endinterface

FILE: src/lcdseq_buf.sv
module lcdseq_buf #(
    parameter int BUFFER_CHARS = 80
) (
    input  logic                            clk,
    input  lcdseq_pkg::buf_wr_t             wr,
    input  logic [$clog2(BUFFER_CHARS)-1:0] rd_addr,
    output logic [7:0]                      rd_data
);
    localparam int AW = $clog2(BUFFER_CHARS);

    logic [7:0] mem [BUFFER_CHARS];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr[AW-1:0]] <= wr.data;
        end
    end

    // A write in the same cycle as the read of its entry is passed straight through.
    always_ff @(posedge clk)
    begin
        if (wr.en && (wr.addr == 7'(rd_addr)))
        begin
            rd_data_reg <= wr.data;
        end
        else
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

FILE: src/lcdseq_ctrl.sv
module lcdseq_ctrl #(
    parameter int BUFFER_CHARS = 80
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [15:0]                     cfg_data,
    input  logic                            step,
    input  lcdseq_pkg::item_t               item,
    input  logic [7:0]                      rd_data,
    output logic                            emit,
    output lcdseq_pkg::result_t             res,
    output lcdseq_pkg::buf_wr_t             wr,
    output logic [$clog2(BUFFER_CHARS)-1:0] rd_addr
);
    localparam int PW = $clog2(BUFFER_CHARS);

    logic [15:0]   wait_reg,    wait_next;
    logic          in_init_reg, in_init_next;
    logic [PW-1:0] pos_reg,     pos_next;
    logic [7:0]    pcmd_reg,    pcmd_next;
    logic          refresh_reg, refresh_next;
    logic          reinit_reg,  reinit_next;

    always_comb
    begin
        logic        go;
        logic [PW:0] pos_inc;
        go           = 1'b1;
        pos_inc      = '0;
        wait_next    = wait_reg;
        in_init_next = in_init_reg;
        pos_next     = pos_reg;
        pcmd_next    = pcmd_reg;
        refresh_next = refresh_reg;
        reinit_next  = reinit_reg;
        emit         = 1'b0;
        res          = '0;
        wr           = '0;
        case (item.op)
            lcdseq_pkg::OP_TICK:
            begin
                if (wait_reg != 16'd0)
                begin
                    wait_next = wait_reg - 16'd1;
                    go        = (wait_next == 16'd0);
                end
                if (go)
                begin
                    if (reinit_reg)
                    begin
                        in_init_next = 1'b1;
                        pos_next     = '0;
                        reinit_next  = 1'b0;
                    end
                    if (in_init_next)
                    begin
                        if (pos_next < PW'(lcdseq_pkg::INIT_STEPS))
                        begin
                            pcmd_next = lcdseq_pkg::init_cmd(pos_next[2:0]);
                            wait_next = lcdseq_pkg::init_wait(pos_next[2:0]);
                            pos_next  = pos_next + PW'(1);
                        end
                        else
                        begin
                            in_init_next = 1'b0;
                            pos_next     = '0;
                        end
                    end
                    if (pcmd_next != 8'h00)
                    begin
                        emit         = 1'b1;
                        res.is_data  = 1'b0;
                        res.bus_byte = pcmd_next;
                        pcmd_next    = 8'h00;
                    end
                    else if (refresh_reg)
                    begin
                        emit         = 1'b1;
                        res.is_data  = 1'b1;
                        res.bus_byte = rd_data;
                        pos_inc      = {1'b0, pos_next} + (PW+1)'(1);
                        if (pos_inc >= (PW+1)'(BUFFER_CHARS))
                        begin
                            pos_next     = '0;
                            refresh_next = 1'b0;
                        end
                        else
                        begin
                            pos_next = pos_inc[PW-1:0];
                        end
                        if (pos_next == '0)
                        begin
                            pcmd_next = lcdseq_pkg::CMD_LINE0;
                        end
                        else if (pos_next == PW'(lcdseq_pkg::LINE1_POS))
                        begin
                            pcmd_next = lcdseq_pkg::CMD_LINE1;
                        end
                        else if (pos_next == PW'(lcdseq_pkg::LINE2_POS))
                        begin
                            pcmd_next = lcdseq_pkg::CMD_LINE2;
                        end
                        else if (pos_next == PW'(lcdseq_pkg::LINE3_POS))
                        begin
                            pcmd_next = lcdseq_pkg::CMD_LINE3;
                        end
                    end
                end
            end
            lcdseq_pkg::OP_WRITE:
            begin
                wr.en   = step && (item.index < 7'(BUFFER_CHARS));
                wr.addr = item.index;
                wr.data = lcdseq_pkg::convert_char(item.code);
            end
            lcdseq_pkg::OP_REFRESH:
            begin
                refresh_next = 1'b1;
            end
            lcdseq_pkg::OP_REINIT:
            begin
                reinit_next = 1'b1;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // The store is read at the position the next tick will use; when init is
    // running the only data read that can follow is entry zero.
    always_comb
    begin
        if (step)
        begin
            rd_addr = in_init_next ? '0 : pos_next;
        end
        else
        begin
            rd_addr = in_init_reg ? '0 : pos_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wait_reg    <= lcdseq_pkg::STARTUP_WAIT_RESET;
            in_init_reg <= 1'b1;
            pos_reg     <= '0;
            pcmd_reg    <= 8'h00;
            refresh_reg <= 1'b0;
            reinit_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            wait_reg <= cfg_data;
        end
        else if (step)
        begin
            wait_reg    <= wait_next;
            in_init_reg <= in_init_next;
            pos_reg     <= pos_next;
            pcmd_reg    <= pcmd_next;
            refresh_reg <= refresh_next;
            reinit_reg  <= reinit_next;
        end
    end
endmodule

FILE: src/char_lcd_init_refresh_sequencer_core.sv
// A result enters the result register when its item retires from the input register, and waits there for its transfer.
// Throughput: one item per cycle; the input register drains whenever the result register
// is free or the item gives no bus write.
// The character store is a memory with one registered read port, addressed ahead of time.
// Reset (rst_n low, asynchronous) restarts the startup wait and the init sequence and
// empties both registers; the character store keeps its contents and is not cleared.
module char_lcd_init_refresh_sequencer_core #(
    parameter int BUFFER_CHARS = 80
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [15:0]  cfg_data,
    lcdseq_item_if.sink  item,
    lcdseq_bus_if.source bus
);
    localparam int PW = $clog2(BUFFER_CHARS);

    // Input register: holds the item being worked on this cycle.
    logic              in_vld_reg;
    lcdseq_pkg::item_t in_item_reg;

    // Result register: one bus write waiting for its transfer.
    logic                out_vld_reg, out_vld_next;
    lcdseq_pkg::result_t out_res_reg;

    logic                emit;
    logic                fire;
    lcdseq_pkg::result_t res;
    lcdseq_pkg::buf_wr_t wr;
    logic [PW-1:0]       rd_addr;
    logic [7:0]          rd_data;

    // The held item retires when it gives no bus write or when the result
    // register is empty or being emptied in this cycle.
    assign fire       = in_vld_reg && (!emit || !out_vld_reg || bus.ready);
    assign item.ready = !in_vld_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            in_vld_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            in_item_reg.op    <= lcdseq_pkg::op_t'(item.operation);
            in_item_reg.index <= item.buffer_index;
            in_item_reg.code  <= item.char_code;
        end
    end

    lcdseq_ctrl #(
        .BUFFER_CHARS (BUFFER_CHARS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .step     (fire),
        .item     (in_item_reg),
        .rd_data  (rd_data),
        .emit     (emit),
        .res      (res),
        .wr       (wr),
        .rd_addr  (rd_addr)
    );

    lcdseq_buf #(
        .BUFFER_CHARS (BUFFER_CHARS)
    ) u_buf (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        if (fire && emit)
        begin
            out_vld_next = 1'b1;
        end
        else if (bus.ready)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && emit)
        begin
            out_res_reg <= res;
        end
    end

    assign bus.valid    = out_vld_reg;
    assign bus.is_data  = out_res_reg.is_data;
    assign bus.bus_byte = out_res_reg.bus_byte;
endmodule

FILE: src/lcdseq_checker.sv
module lcdseq_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       bus_valid,
    input logic       bus_ready,
    input logic       bus_is_data,
    input logic [7:0] bus_byte
);
    // A result waiting for its transfer is not withdrawn.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        bus_valid && !bus_ready |=> bus_valid)
        else $error("bus result dropped before transfer");

    // Only pending commands that are nonzero are ever written.
    a_cmd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        bus_valid && !bus_is_data |-> bus_byte != 8'h00)
        else $error("command write with zero byte");

    // Reset leaves no result on the bus.
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !bus_valid)
        else $error("bus result valid during reset");
endmodule

bind char_lcd_init_refresh_sequencer_core lcdseq_checker u_lcdseq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .bus_valid   (bus.valid),
    .bus_ready   (bus.ready),
    .bus_is_data (bus.is_data),
    .bus_byte    (bus.bus_byte)
);
